/* src/deq_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package deq_pkg;

    // Operation codes carried in the op field of a request.
    typedef enum logic [1:0] {
        OP_PUSH_BACK  = 2'd0,
        OP_PUSH_FRONT = 2'd1,
        OP_POP_FRONT  = 2'd2,
        OP_POP_BACK   = 2'd3
    } op_code_t;

    // Status codes carried in the status field of a response.
    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_EMPTY = 2'd1;
    localparam logic [1:0] STAT_FULL  = 2'd2;

    localparam int unsigned IO_WIDTH    = 32;
    localparam int unsigned COUNT_WIDTH = 5;

    typedef struct packed {
        logic [1:0]                 op;
        logic signed [IO_WIDTH-1:0] value;
    } req_item_t;

    typedef struct packed {
        logic signed [IO_WIDTH-1:0] popped;
        logic [1:0]                 status;
        logic signed [IO_WIDTH-1:0] front_value;
        logic signed [IO_WIDTH-1:0] back_value;
        logic                       is_empty;
        logic [COUNT_WIDTH-1:0]     fill_count;
    } rsp_item_t;

    // Per-cycle command broadcast to every cell; already qualified by
    // the full and empty checks, at most one bit is set.
    typedef struct packed {
        logic push_front;
        logic push_back;
        logic pop_front;
        logic pop_back;
    } cell_ctl_t;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_GATHER,
        PH_HOLD
    } phase_t;

endpackage

`default_nettype wire

/* src/deq_cell.sv */
`timescale 1ns / 1ps
`default_nettype none

module deq_cell #(
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire deq_pkg::cell_ctl_t    ctl,
    input  wire logic [DATA_WIDTH-1:0] push_val,
    input  wire logic [DATA_WIDTH-1:0] lo_value,
    input  wire logic                  lo_valid,
    input  wire logic [DATA_WIDTH-1:0] up_value,
    input  wire logic                  up_valid,
    output logic [DATA_WIDTH-1:0]      value,
    output logic                       valid,
    output logic                       last
);

    logic [DATA_WIDTH-1:0] value_reg;
    logic [DATA_WIDTH-1:0] value_next;
    logic                  valid_reg;
    logic                  valid_next;

    always_comb
    begin
        value_next = value_reg;
        valid_next = valid_reg;
        if (ctl.push_front)
        begin
            // advance toward the back
            value_next = lo_value;
            valid_next = lo_valid;
        end
        else if (ctl.pop_front)
        begin
            // advance toward the front
            value_next = up_value;
            valid_next = up_valid;
        end
        else if (ctl.push_back)
        begin
            // first free cell takes the value
            if (!valid_reg && lo_valid)
            begin
                value_next = push_val;
                valid_next = 1'b1;
            end
        end
        else if (ctl.pop_back)
        begin
            // drop the last occupied cell
            if (valid_reg && !up_valid)
            begin
                valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;
    assign valid = valid_reg;
    assign last  = valid_reg && !up_valid;

endmodule

`default_nettype wire

/* src/deq_gather.sv */
`timescale 1ns / 1ps
`default_nettype none

module deq_gather #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic [DEPTH-1:0][DATA_WIDTH-1:0] values,
    input  wire logic [DEPTH-1:0]                 last,
    output logic [DATA_WIDTH-1:0]                 back
);

    // At most one cell flags itself last; merge the flagged value.
    always_comb
    begin
        back = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            back = back | (values[i] & {DATA_WIDTH{last[i]}});
        end
    end

endmodule

`default_nettype wire

/* src/double_ended_queue.sv */
// Double-ended queue of signed integers held in a row of DEPTH cells. The
// front item always sits in cell 0 and the occupied cells form one
// contiguous run; a push or pop at the front moves every cell's contents one
// place along the row, while a push or pop at the back touches only the cell
// at the end of the run. Each request transfer (op, value) yields exactly one
// response transfer carrying the popped value (-1 when nothing was removed),
// a status (ok, pop on empty, push on full dropped), the front and back values
// after the operation (-1 when empty), an empty flag and the fill count. A
// new request is taken only once the previous response has been taken: the
// cell row updates in the accept (IDLE) phase, the new front and back values
// are gathered into the response registers in the GATHER phase, and the
// response is offered in the HOLD phase until it is taken.
// req_stall stays high from acceptance until the response transfer
// completes. Values are stored in DATA_WIDTH bits and returned sign-extended
// to 32 bits.
`timescale 1ns / 1ps
`default_nettype none

module double_ended_queue #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               req_valid,
    output logic                    req_stall,
    input  wire deq_pkg::req_item_t req,
    output logic                    rsp_valid,
    input  wire logic               rsp_stall,
    output deq_pkg::rsp_item_t      rsp
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int IW = deq_pkg::IO_WIDTH;
    localparam int FW = deq_pkg::COUNT_WIDTH;

    deq_pkg::phase_t phase_reg;
    deq_pkg::phase_t phase_next;

    logic [CW-1:0]  count_reg;
    logic [CW-1:0]  count_next;

    logic [IW-1:0]  popped_reg;
    logic [IW-1:0]  popped_next;
    logic [1:0]     status_reg;
    logic [1:0]     status_next;
    logic [IW-1:0]  front_reg;
    logic [IW-1:0]  back_reg;
    logic           empty_reg;
    logic [FW-1:0]  fill_reg;

    logic           req_xfer;
    logic           gather_load;
    logic           is_full;
    logic           is_void;

    deq_pkg::cell_ctl_t ctl;

    logic [DATA_WIDTH-1:0]             push_val;
    logic [DEPTH-1:0][DATA_WIDTH-1:0]  cell_value;
    logic [DEPTH-1:0]                  cell_valid;
    logic [DEPTH-1:0]                  cell_last;
    logic [DATA_WIDTH-1:0]             back_raw;
    logic [IW-1:0]                     front_ext;
    logic [IW-1:0]                     back_ext;
    logic [FW-1:0]                     fill_ext;

    assign req_xfer = req_valid && !req_stall;
    assign is_full  = (count_reg == CW'(DEPTH));
    assign is_void  = (count_reg == '0);

    // Fit the 32-bit request value to the storage width, and sign-extend
    // stored values back out to 32 bits.
    generate
        if (DATA_WIDTH <= IW)
        begin : g_narrow_in
            assign push_val = req.value[DATA_WIDTH-1:0];
        end
        else
        begin : g_wide_in
            assign push_val = {{(DATA_WIDTH-IW){req.value[IW-1]}}, req.value};
        end

        if (DATA_WIDTH >= IW)
        begin : g_wide_out
            assign front_ext = cell_value[0][IW-1:0];
            assign back_ext  = back_raw[IW-1:0];
        end
        else
        begin : g_narrow_out
            assign front_ext = {{(IW-DATA_WIDTH){cell_value[0][DATA_WIDTH-1]}},
                                cell_value[0]};
            assign back_ext  = {{(IW-DATA_WIDTH){back_raw[DATA_WIDTH-1]}}, back_raw};
        end

        if (CW >= FW)
        begin : g_fill_trunc
            assign fill_ext = count_reg[FW-1:0];
        end
        else
        begin : g_fill_ext
            assign fill_ext = {{(FW-CW){1'b0}}, count_reg};
        end
    endgenerate

    // Decode the accepted request into one row command, rejecting pushes
    // on a full row and pops on an empty one.
    always_comb
    begin
        ctl         = '0;
        count_next  = count_reg;
        popped_next = popped_reg;
        status_next = status_reg;
        if (req_xfer)
        begin
            popped_next = '1;
            status_next = deq_pkg::STAT_OK;
            case (deq_pkg::op_code_t'(req.op))
                deq_pkg::OP_PUSH_BACK:
                begin
                    if (is_full)
                    begin
                        status_next = deq_pkg::STAT_FULL;
                    end
                    else
                    begin
                        ctl.push_back = 1'b1;
                        count_next    = count_reg + 1'b1;
                    end
                end
                deq_pkg::OP_PUSH_FRONT:
                begin
                    if (is_full)
                    begin
                        status_next = deq_pkg::STAT_FULL;
                    end
                    else
                    begin
                        ctl.push_front = 1'b1;
                        count_next     = count_reg + 1'b1;
                    end
                end
                deq_pkg::OP_POP_FRONT:
                begin
                    if (is_void)
                    begin
                        status_next = deq_pkg::STAT_EMPTY;
                    end
                    else
                    begin
                        ctl.pop_front = 1'b1;
                        popped_next   = front_ext;
                        count_next    = count_reg - 1'b1;
                    end
                end
                deq_pkg::OP_POP_BACK:
                begin
                    if (is_void)
                    begin
                        status_next = deq_pkg::STAT_EMPTY;
                    end
                    else
                    begin
                        ctl.pop_back = 1'b1;
                        popped_next  = back_ext;
                        count_next   = count_reg - 1'b1;
                    end
                end
                default:
                begin
                    status_next = deq_pkg::STAT_OK;
                end
            endcase
        end
    end

    // Cell row: cell 0 sees the incoming value as its lower neighbor, the
    // last cell sees an always-empty upper neighbor.
    generate
        for (genvar i = 0; i < DEPTH; i++)
        begin : g_cell
            logic [DATA_WIDTH-1:0] lo_value;
            logic                  lo_valid;
            logic [DATA_WIDTH-1:0] up_value;
            logic                  up_valid;

            if (i == 0)
            begin : g_first
                assign lo_value = push_val;
                assign lo_valid = 1'b1;
            end
            else
            begin : g_mid_lo
                assign lo_value = cell_value[i-1];
                assign lo_valid = cell_valid[i-1];
            end

            if (i == DEPTH - 1)
            begin : g_final
                assign up_value = '0;
                assign up_valid = 1'b0;
            end
            else
            begin : g_mid_up
                assign up_value = cell_value[i+1];
                assign up_valid = cell_valid[i+1];
            end

            deq_cell #(
                .DATA_WIDTH(DATA_WIDTH)
            ) u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .ctl      (ctl),
                .push_val (push_val),
                .lo_value (lo_value),
                .lo_valid (lo_valid),
                .up_value (up_value),
                .up_valid (up_valid),
                .value    (cell_value[i]),
                .valid    (cell_valid[i]),
                .last     (cell_last[i])
            );
        end
    endgenerate

    // Pick the back value out of the row.
    deq_gather #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_gather (
        .values (cell_value),
        .last   (cell_last),
        .back   (back_raw)
    );

    // Sequencer: accept, gather, hold until the response transfer.
    always_comb
    begin
        phase_next = phase_reg;
        case (phase_reg)
            deq_pkg::PH_IDLE:
            begin
                if (req_valid)
                begin
                    phase_next = deq_pkg::PH_GATHER;
                end
            end
            deq_pkg::PH_GATHER:
            begin
                phase_next = deq_pkg::PH_HOLD;
            end
            deq_pkg::PH_HOLD:
            begin
                if (!rsp_stall)
                begin
                    phase_next = deq_pkg::PH_IDLE;
                end
            end
            default:
            begin
                phase_next = deq_pkg::PH_IDLE;
            end
        endcase
    end

    always_comb
    begin
        req_stall   = 1'b1;
        rsp_valid   = 1'b0;
        gather_load = 1'b0;
        case (phase_reg)
            deq_pkg::PH_IDLE:
            begin
                req_stall = 1'b0;
            end
            deq_pkg::PH_GATHER:
            begin
                gather_load = 1'b1;
            end
            deq_pkg::PH_HOLD:
            begin
                rsp_valid = 1'b1;
            end
            default:
            begin
                req_stall = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= deq_pkg::PH_IDLE;
            count_reg <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            count_reg <= count_next;
        end
    end

    // Response payload; hold while the response is stalled.
    always_ff @(posedge clk)
    begin
        popped_reg <= popped_next;
        status_reg <= status_next;
        if (gather_load)
        begin
            empty_reg <= is_void;
            fill_reg  <= fill_ext;
            front_reg <= is_void ? '1 : front_ext;
            back_reg  <= is_void ? '1 : back_ext;
        end
    end

    assign rsp.popped      = popped_reg;
    assign rsp.status      = status_reg;
    assign rsp.front_value = front_reg;
    assign rsp.back_value  = back_reg;
    assign rsp.is_empty    = empty_reg;
    assign rsp.fill_count  = fill_reg;

    // The count always matches the number of occupied cells.
    a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(cell_valid) == int'(count_reg))
        else $error("fill count disagrees with occupied cells");

    // Occupied cells form one run starting at cell 0.
    a_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
        ((cell_valid + 1'b1) & cell_valid) == '0)
        else $error("occupied cells are not contiguous from the front");

    // An accepted push on a non-full row grows the count by one.
    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (req_xfer && !is_full && !req.op[1]) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("push did not grow the count");

endmodule

`default_nettype wire
